@@ sv/stpl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stpl_pkg;

    // Default queue depth of the playlist store
    localparam int QUEUE_DEPTH_DEF = 10;
    // Longest playlist that one announcement can produce
    localparam int PLAYLIST_MAX    = 10;
    // Completion pattern: two replies of this length back to back
    localparam int REPLY_LEN       = 10;
    localparam int REPLY_TOTAL     = 2 * REPLY_LEN;

    localparam logic [7:0] FRM_START    = 8'h7E;
    localparam logic [7:0] FRM_VERSION  = 8'hFF;
    localparam logic [7:0] FRM_LENGTH   = 8'h06;
    localparam logic [7:0] FRM_END      = 8'hEF;
    localparam logic [7:0] FRM_CMD_PLAY = 8'h0F;
    localparam logic [7:0] FRM_CMD_VOL  = 8'h06;
    localparam logic [7:0] FRM_CMD_DONE = 8'h3D;

    localparam logic [7:0] SND_PROMPT   = 8'd91;
    localparam logic [7:0] SND_HOUR_OFS = 8'd100;
    localparam logic [7:0] SND_TEN      = 8'd10;
    localparam logic [7:0] SND_HOURS    = 8'd11;
    localparam logic [7:0] SND_MINUTES  = 8'd12;
    localparam logic [7:0] SND_NOW      = 8'd13;
    localparam logic [7:0] SND_TIME_IS  = 8'd14;
    localparam logic [7:0] SND_ZERO     = 8'd0;
    localparam logic [7:0] HOURLY_FOLDER = 8'd11;
    localparam logic [4:0] HOUR_NONE    = 5'd25;

    typedef enum logic [1:0] {
        CMD_SPEAK  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_RX     = 2'd2,
        CMD_VOLUME = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_FOLDER = 2'd1,
        REG_VOLUME = 2'd2,
        REG_NONE   = 2'd3
    } reg_e_t;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
    } out_item_t;

    // One outgoing frame: command byte and the two data bytes
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] hi;
        logic [7:0] lo;
    } frame_req_t;

    typedef struct packed {
        logic [3:0]                  len;
        logic [PLAYLIST_MAX-1:0][7:0] snd;
    } playlist_t;

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v, input logic [2:0] t);
        logic [5:0] r;
        r = v - 6'(t) * 6'd10;
        return r[3:0];
    endfunction

    function automatic playlist_t build_playlist(input logic real_mode,
                                                 input logic [4:0] h,
                                                 input logic [5:0] m);
        playlist_t  pl;
        logic [3:0] n;
        logic [2:0] ht;
        logic [3:0] hu;
        logic [2:0] mt;
        logic [3:0] mu;
        pl.snd = '0;
        n      = 4'd0;
        ht     = tens_of({1'b0, h});
        hu     = units_of({1'b0, h}, ht);
        mt     = tens_of(m);
        mu     = units_of(m, mt);
        if (real_mode) begin
            pl.snd[0] = SND_PROMPT;
            pl.snd[1] = SND_HOUR_OFS + 8'(h);
            pl.snd[2] = 8'(m);
            n = 4'd3;
        end else begin
            pl.snd[0] = SND_NOW;
            pl.snd[1] = SND_TIME_IS;
            n = 4'd2;
            if (h <= 5'd10) begin
                pl.snd[n] = 8'(h); n = n + 4'd1;
            end else begin
                if (h >= 5'd20) begin
                    pl.snd[n] = 8'(ht); n = n + 4'd1;
                end
                pl.snd[n] = SND_TEN; n = n + 4'd1;
                if (hu != 4'd0) begin
                    pl.snd[n] = 8'(hu); n = n + 4'd1;
                end
            end
            pl.snd[n] = SND_HOURS; n = n + 4'd1;
            if (m < 6'd10) begin
                pl.snd[n] = SND_ZERO; n = n + 4'd1;
                if (m != 6'd0) begin
                    pl.snd[n] = 8'(m); n = n + 4'd1;
                end
            end else begin
                pl.snd[n] = 8'(mt); n = n + 4'd1;
                pl.snd[n] = SND_TEN; n = n + 4'd1;
                if (m > 6'd10 && mu != 4'd0) begin
                    pl.snd[n] = 8'(mu); n = n + 4'd1;
                end
            end
            pl.snd[n] = SND_MINUTES; n = n + 4'd1;
        end
        pl.len = n;
        return pl;
    endfunction

    // Completion pattern byte; zero marks a wildcard
    function automatic logic [7:0] reply_byte(input logic [4:0] idx);
        logic [4:0] p;
        logic [7:0] b;
        p = (idx >= 5'(REPLY_LEN)) ? idx - 5'(REPLY_LEN) : idx;
        unique case (p)
            5'd0:    b = FRM_START;
            5'd1:    b = FRM_VERSION;
            5'd2:    b = FRM_LENGTH;
            5'd3:    b = FRM_CMD_DONE;
            5'd9:    b = FRM_END;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] frame_byte(input frame_req_t req, input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = FRM_START;
            3'd1:    b = FRM_VERSION;
            3'd2:    b = FRM_LENGTH;
            3'd3:    b = req.cmd;
            3'd4:    b = 8'h00;
            3'd5:    b = req.hi;
            3'd6:    b = req.lo;
            default: b = FRM_END;
        endcase
        return b;
    endfunction

endpackage

@@ sv/stpl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stpl_front #(
    parameter int QUEUE_DEPTH = stpl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  stpl_pkg::in_item_t   item,
    input  wire                  cfg_we,
    input  wire  [1:0]           cfg_index,
    input  wire  [7:0]           cfg_data,
    output logic                 req_push,
    output stpl_pkg::frame_req_t req
);
    import stpl_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LOAD_N = (QUEUE_DEPTH < PLAYLIST_MAX) ? QUEUE_DEPTH : PLAYLIST_MAX;

    logic [7:0]       queue_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] play_reg, play_next;
    logic [4:0]       match_reg, match_next;
    logic [4:0]       last_hour_reg, last_hour_next;
    logic             override_reg, override_next;
    logic             mode_reg;
    logic [7:0]       folder_reg;
    logic [4:0]       volume_reg;

    logic             do_speak;
    logic             eff_mode;
    logic             eff_override;
    logic [7:0]       eff_folder;
    playlist_t        plist;
    logic [4:0]       match_idx;
    logic [7:0]       pat;
    logic [CNT_W-1:0] plist_cnt;

    always_comb
    begin
        count_next     = count_reg;
        play_next      = play_reg;
        match_next     = match_reg;
        last_hour_next = last_hour_reg;
        override_next  = override_reg;
        do_speak       = 1'b0;
        req_push       = 1'b0;
        req            = '{cmd: FRM_CMD_PLAY, hi: 8'h00, lo: 8'h00};
        match_idx      = (match_reg >= 5'(REPLY_TOTAL)) ? 5'd0 : match_reg;
        pat            = reply_byte(match_idx);

        if (accept) begin
            unique case (cmd_e_t'(item.command))
                CMD_SPEAK:
                begin
                    do_speak = 1'b1;
                end
                CMD_TICK:
                begin
                    if (item.minute == 6'd0 && item.hour != last_hour_reg) begin
                        do_speak       = 1'b1;
                        override_next  = 1'b1;
                        last_hour_next = item.hour;
                    end
                end
                CMD_RX:
                begin
                    if (pat == 8'h00 || item.rx_byte == pat) begin
                        if (match_idx == 5'(REPLY_TOTAL - 1)) begin
                            match_next = 5'd0;
                            if (play_reg < count_reg && play_reg < CNT_W'(QUEUE_DEPTH)) begin
                                req_push  = 1'b1;
                                req.lo    = queue_mem[play_reg[IDX_W-1:0]];
                                play_next = play_reg + CNT_W'(1);
                            end
                        end else begin
                            match_next = match_idx + 5'd1;
                        end
                    end else begin
                        match_next = 5'd0;
                    end
                end
                CMD_VOLUME:
                begin
                    req_push = 1'b1;
                    req.cmd  = FRM_CMD_VOL;
                    req.lo   = {3'b000, volume_reg};
                end
                default:
                begin
                    req_push = 1'b0;
                end
            endcase
        end

        // The hourly override takes effect on the very announcement that sets it
        eff_override = override_next;
        eff_mode     = eff_override | mode_reg;
        eff_folder   = eff_override ? HOURLY_FOLDER : folder_reg;
        plist        = build_playlist(eff_mode, item.hour, item.minute);
        plist_cnt    = (CNT_W'(plist.len) > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                                 : CNT_W'(plist.len);
        if (do_speak) begin
            count_next = plist_cnt;
            play_next  = CNT_W'(1);
            match_next = 5'd0;
            req_push   = 1'b1;
            req.lo     = plist.snd[0];
        end
        if (req.cmd == FRM_CMD_PLAY) begin
            req.hi = eff_folder;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            play_reg      <= '0;
            match_reg     <= '0;
            last_hour_reg <= HOUR_NONE;
            override_reg  <= 1'b0;
            mode_reg      <= 1'b0;
            folder_reg    <= 8'd0;
            volume_reg    <= 5'd18;
        end else begin
            count_reg     <= count_next;
            play_reg      <= play_next;
            match_reg     <= match_next;
            last_hour_reg <= last_hour_next;
            override_reg  <= override_next;
            if (cfg_we) begin
                unique case (reg_e_t'(cfg_index))
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_FOLDER: folder_reg <= cfg_data;
                    REG_VOLUME: volume_reg <= cfg_data[4:0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // Load the playlist in parallel on a speak, up to the queue depth
    always_ff @(posedge clk)
    begin
        if (do_speak) begin
            for (int i = 0; i < LOAD_N; i++) begin
                queue_mem[i] <= plist.snd[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/stpl_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stpl_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  stpl_pkg::frame_req_t wr_data,
    output logic                 fifo_full,
    input  wire                  rd_en,
    output logic                 rd_valid,
    output stpl_pkg::frame_req_t rd_data
);
    import stpl_pkg::*;

    frame_req_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb
    begin
        fifo_full   = (fill_reg == 2'd2);
        rd_valid    = (fill_reg != 2'd0);
        rd_data     = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        fill_next   = fill_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/stpl_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stpl_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    input  stpl_pkg::frame_req_t req,
    output logic                 req_done,
    output logic                 empty,
    input  wire                  pop,
    output stpl_pkg::out_item_t  result
);
    import stpl_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    out_item_t  out_reg;
    logic       load;

    always_comb
    begin
        load       = req_valid && (!valid_reg || pop);
        req_done   = load && (pos_reg == 3'd7);
        pos_next   = load ? pos_reg + 3'd1 : pos_reg;
        valid_next = load ? 1'b1 : (pop ? 1'b0 : valid_reg);
        empty      = !valid_reg;
        result     = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg.tx_byte    <= frame_byte(req, pos_reg);
            out_reg.frame_last <= (pos_reg == 3'd7);
        end
    end

endmodule

`default_nettype wire

@@ sv/spoken_time_playlist_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                              Transfer when
// command   push, full, request                  push && !full
// result    empty, pop, result                   pop && !empty
// config    cfg_valid, cfg_ready, cfg_index/data cfg_valid && cfg_ready
//
// Each command is taken by the front end when it transfers; a command that sends a frame
// yields 8 result bytes, one per cycle from the byte serializer while pop is held and
// frames are queued. The two-entry frame queue sets how far the front runs ahead.
// Reset clears all control state; playlist entries are undefined until a speak.
// A stalled pop holds the current byte; full rises only when the frame queue is full.

module spoken_time_playlist_sequencer #(
    parameter int QUEUE_DEPTH = stpl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  stpl_pkg::in_item_t  request,
    output logic                empty,
    input  wire                 pop,
    output stpl_pkg::out_item_t result,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [1:0]          cfg_index,
    input  wire  [7:0]          cfg_data
);
    import stpl_pkg::*;

    logic       accept;
    logic       fifo_full;
    logic       req_push;
    frame_req_t req_in;
    logic       req_valid;
    frame_req_t req_head;
    logic       req_done;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;
    // Hold off commands while the frame queue has no room
    assign full      = fifo_full;
    assign accept    = push && !fifo_full;

    // Front end: decode commands, keep the playlist and reply matcher
    stpl_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (request),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_push  (req_push),
        .req       (req_in)
    );

    // Decouple decode from byte serialization
    stpl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (req_push),
        .wr_data   (req_in),
        .fifo_full (fifo_full),
        .rd_en     (req_done),
        .rd_valid  (req_valid),
        .rd_data   (req_head)
    );

    // Back end: advance through the eight frame bytes into the output register
    stpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req_head),
        .req_done  (req_done),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ tb/sv/stpl_frame_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stpl_frame_checker #(
    parameter int DEPTH = stpl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire                 full,
    input  stpl_pkg::in_item_t  request,
    input  wire                 empty,
    input  wire                 pop,
    input  stpl_pkg::out_item_t result,
    input  wire                 cfg_valid,
    input  wire                 cfg_ready,
    input  wire  [1:0]          cfg_index,
    input  wire  [7:0]          cfg_data,
    output int                  owed_count,
    output int                  mismatch_count
);
    import stpl_pkg::*;

    // Register copies
    logic       real_voice;
    logic [7:0] folder_reg;
    logic [4:0] volume_reg;

    // Playlist and reply tracking
    logic [7:0] playlist [DEPTH];
    int         playlist_len;
    int         next_entry;
    int         reply_pos;
    logic [4:0] hour_done;
    logic       hourly_mode;

    out_item_t  owed_bytes [$];

    task automatic clear_state();
        real_voice     = 1'b0;
        folder_reg     = 8'h00;
        volume_reg     = 5'd18;
        playlist_len   = 0;
        next_entry     = 0;
        reply_pos      = 0;
        hour_done      = HOUR_NONE;
        hourly_mode    = 1'b0;
        mismatch_count = 0;
        owed_bytes.delete();
    endtask

    task automatic queue_frame(input logic [7:0] op, input logic [7:0] hi,
                               input logic [7:0] lo);
        logic [7:0] bytes [8];
        out_item_t  o;
        bytes[0] = FRM_START;
        bytes[1] = FRM_VERSION;
        bytes[2] = FRM_LENGTH;
        bytes[3] = op;
        bytes[4] = 8'h00;
        bytes[5] = hi;
        bytes[6] = lo;
        bytes[7] = FRM_END;
        for (int i = 0; i < 8; i++) begin
            o.tx_byte    = bytes[i];
            o.frame_last = (i == 7);
            owed_bytes.push_back(o);
        end
    endtask

    task automatic add_sound(input logic [7:0] s);
        // drop on overflow
        if (playlist_len < DEPTH) begin
            playlist[playlist_len] = s;
            playlist_len++;
        end
    endtask

    task automatic play_sound(input logic [7:0] s);
        queue_frame(FRM_CMD_PLAY, hourly_mode ? HOURLY_FOLDER : folder_reg, s);
    endtask

    task automatic announce(input logic [4:0] h, input logic [5:0] m);
        logic [7:0] hv;
        logic [7:0] mv;
        hv = {3'b000, h};
        mv = {2'b00, m};
        playlist_len = 0;
        reply_pos    = 0;
        if (hourly_mode || real_voice) begin
            add_sound(SND_PROMPT);
            add_sound(SND_HOUR_OFS + hv);
            add_sound(mv);
        end else begin
            add_sound(SND_NOW);
            add_sound(SND_TIME_IS);
            if (hv <= 10) begin
                add_sound(hv);
            end else if (hv < 20) begin
                add_sound(SND_TEN);
                if (hv % 10 != 0) add_sound(8'(hv % 10));
            end else begin
                add_sound(8'(hv / 10));
                add_sound(SND_TEN);
                if (hv % 10 != 0) add_sound(8'(hv % 10));
            end
            add_sound(SND_HOURS);
            if (mv == 0) begin
                add_sound(SND_ZERO);
            end else if (mv < 10) begin
                add_sound(SND_ZERO);
                add_sound(mv);
            end else begin
                add_sound(8'(mv / 10));
                add_sound(SND_TEN);
            end
            if (mv > 10 && mv % 10 != 0) add_sound(8'(mv % 10));
            add_sound(SND_MINUTES);
        end
        next_entry = 1;
        play_sound(playlist_len > 0 ? playlist[0] : SND_ZERO);
    endtask

    // Zero means any byte
    function automatic logic [7:0] done_reply_byte(input int pos);
        case (pos % REPLY_LEN)
            0:       return FRM_START;
            1:       return FRM_VERSION;
            2:       return FRM_LENGTH;
            3:       return FRM_CMD_DONE;
            9:       return FRM_END;
            default: return 8'h00;
        endcase
    endfunction

    task automatic predict_request(input in_item_t req);
        logic [7:0] want;
        case (req.command)
            CMD_SPEAK: announce(req.hour, req.minute);
            CMD_TICK: begin
                if (req.minute == 6'd0 && req.hour != hour_done) begin
                    hourly_mode = 1'b1;
                    announce(req.hour, req.minute);
                    hour_done = req.hour;
                end
            end
            CMD_RX: begin
                want = done_reply_byte(reply_pos);
                if (want == 8'h00 || req.rx_byte == want) begin
                    if (reply_pos == REPLY_TOTAL - 1) begin
                        reply_pos = 0;
                        if (next_entry < playlist_len) begin
                            play_sound(playlist[next_entry]);
                            next_entry++;
                        end
                    end else begin
                        reply_pos++;
                    end
                end else begin
                    reply_pos = 0;
                end
            end
            default: queue_frame(FRM_CMD_VOL, 8'h00, {3'b000, volume_reg});
        endcase
    endtask

    task automatic store_register(input logic [1:0] idx, input logic [7:0] data);
        case (idx)
            REG_MODE:   real_voice = data[0];
            REG_FOLDER: folder_reg = data;
            REG_VOLUME: volume_reg = data[4:0];
            default:    ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t due;
        if (!rst_n) begin
            clear_state();
            owed_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) store_register(cfg_index, cfg_data);
            if (push && !full) predict_request(request);
            if (pop && !empty) begin
                if (owed_bytes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected byte: expected none, actual %h last %b",
                             $time, result.tx_byte, result.frame_last);
                end else begin
                    due = owed_bytes.pop_front();
                    if (result.tx_byte !== due.tx_byte) begin
                        mismatch_count++;
                        $display("%0t: tx_byte mismatch: expected %h, actual %h",
                                 $time, due.tx_byte, result.tx_byte);
                    end
                    if (result.frame_last !== due.frame_last) begin
                        mismatch_count++;
                        $display("%0t: frame_last mismatch: expected %b, actual %b",
                                 $time, due.frame_last, result.frame_last);
                    end
                end
            end
            owed_count <= owed_bytes.size();
        end
    end

endmodule

@@ tb/sv/spoken_time_playlist_sequencer_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spoken_time_playlist_sequencer_test;
    import stpl_pkg::*;

    // Generous bound on the whole run; a hang ends here
    localparam int CYCLE_LIMIT   = 400000;
    // Quiet cycles after the last owed byte: frame queue plus serializer
    localparam int SETTLE_CYCLES = 24;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data  = 8'h00;
    in_item_t   request   = '0;
    logic       full;
    logic       empty;
    logic       cfg_ready;
    out_item_t  result;

    int         owed_count;
    int         mismatch_count;
    int         items_sent = 0;
    // Suppress random idling on both sides while set
    logic       steady = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spoken_time_playlist_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stpl_frame_checker frame_audit (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .request        (request),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .owed_count     (owed_count),
        .mismatch_count (mismatch_count)
    );

    // Drop pop at random about 27 times in 100, never while steady
    always @(posedge clk) begin
        pop <= steady || ($urandom_range(99) >= 27);
    end

    // Hold push high until the transfer; leave it high so that a following item
    // goes out back to back. Drop it only while idling at random or when settling.
    task automatic send_request(input cmd_e_t cmd, input logic [4:0] h,
                                input logic [5:0] m, input logic [7:0] rx);
        in_item_t req;
        req.command = cmd;
        req.hour    = h;
        req.minute  = m;
        req.rx_byte = rx;
        if (!steady) begin
            while ($urandom_range(99) < 27) begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push    <= 1'b1;
        request <= req;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
    endtask

    // Send one completion pattern: two player replies with random wildcard bytes.
    // When spoiled, corrupt one fixed byte so the match falls back to the start.
    task automatic send_completion(input bit spoil);
        logic [7:0] b;
        int         bad_pos;
        int         pick;
        bad_pos = -1;
        if (spoil) begin
            pick    = $urandom_range(4);
            bad_pos = ((pick == 4) ? 9 : pick) + REPLY_LEN * $urandom_range(1);
        end
        for (int i = 0; i < REPLY_TOTAL; i++) begin
            case (i % REPLY_LEN)
                0:       b = FRM_START;
                1:       b = FRM_VERSION;
                2:       b = FRM_LENGTH;
                3:       b = FRM_CMD_DONE;
                9:       b = FRM_END;
                default: b = 8'($urandom_range(255));
            endcase
            if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            send_request(CMD_RX, 5'($urandom), 6'($urandom), b);
        end
    endtask

    // Keep valid high across back-to-back register writes
    task automatic write_reg(input reg_e_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] mode, input logic [7:0] folder,
                             input logic [7:0] vol);
        write_reg(REG_MODE, mode);
        write_reg(REG_FOLDER, folder);
        write_reg(REG_VOLUME, vol);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop push, wait for every owed byte, then let the block go quiet
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mix of commands; most items are completion patterns, which is what walks a
    // playlist forward. Hourly ticks with minute zero only where allowed, since
    // they lock the block into the hourly voice for the rest of the run.
    task automatic random_burst(input int count, input bit allow_hourly);
        int goal;
        int r;
        goal = items_sent + count;
        while (items_sent < goal) begin
            r = $urandom_range(99);
            if (r < 18) begin
                send_request(CMD_SPEAK, 5'($urandom), 6'($urandom), 8'($urandom));
            end else if (r < 26) begin
                send_request(CMD_TICK, 5'($urandom),
                             (allow_hourly && $urandom_range(2) == 0) ?
                                 6'd0 : 6'($urandom_range(1, 63)),
                             8'($urandom));
            end else if (r < 36) begin
                send_request(CMD_VOLUME, 5'($urandom), 6'($urandom), 8'($urandom));
            end else if (r < 52) begin
                // stray bytes, some of which open a partial match
                send_request(CMD_RX, 5'($urandom), 6'($urandom),
                             ($urandom_range(3) == 0) ? FRM_START : 8'($urandom_range(255)));
            end else begin
                send_completion($urandom_range(99) < 15);
            end
        end
    endtask

    initial begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: simple voice, folder 0, volume 18
        send_request(CMD_VOLUME, 5'd0, 6'd0, 8'h00);
        send_request(CMD_TICK, HOUR_NONE, 6'd0, 8'h00);    // same hour as after reset
        send_request(CMD_TICK, 5'd5, 6'd7, 8'h00);         // not on the hour
        send_request(CMD_SPEAK, 5'd23, 6'd59, 8'hFF);      // longest simple playlist
        send_completion(1'b1);                             // reply mismatch
        send_completion(1'b0);
        settle();

        // Unused register index, then real voice at the top extremes
        write_reg(REG_NONE, 8'hA5);
        configure(8'h01, 8'hFF, 8'd30);
        send_request(CMD_SPEAK, 5'd31, 6'd63, 8'h00);      // out of range, sent as given
        send_request(CMD_SPEAK, 5'd0, 6'd0, 8'h00);        // restart before any reply
        send_completion(1'b0);
        send_completion(1'b0);
        send_completion(1'b0);                             // playlist exhausted
        send_request(CMD_VOLUME, 5'd31, 6'd63, 8'hFF);
        settle();

        // Simple voice, volume above 30
        configure(8'hFE, 8'h00, 8'h1F);
        send_request(CMD_SPEAK, 5'd10, 6'd10, 8'h00);
        send_request(CMD_SPEAK, 5'd19, 6'd5, 8'h00);
        send_request(CMD_SPEAK, 5'd20, 6'd11, 8'h00);
        send_request(CMD_VOLUME, 5'd0, 6'd0, 8'h00);
        settle();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       configure(8'h00, 8'h00, 8'h00);
                1:       configure(8'h01, 8'hFF, 8'd30);
                default: configure(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            steady = (phase == 2);
            if (phase == 5) begin
                // Hourly announce, then the same hour again stays silent
                send_request(CMD_TICK, 5'd7, 6'd0, 8'h00);
                send_request(CMD_TICK, 5'd7, 6'd0, 8'h00);
                send_completion(1'b0);
                settle();
                // Registers still take writes; only volume shows through
                configure(8'h00, 8'h55, 8'd3);
                send_request(CMD_VOLUME, 5'd0, 6'd0, 8'h00);
                send_request(CMD_SPEAK, 5'd12, 6'd34, 8'h00);
            end
            // The steady phase runs longest
            random_burst((phase == 2) ? 40 : 8, phase >= 4);
            settle();
        end
        steady = 1'b0;

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
